// ===== src/shp_pkg.sv =====
// Shared types and constants for the 3x3 sharpen stream block.
// No dependencies; every other file but shp_stream_if imports this package.
package shp_pkg;

	typedef logic [23:0] pix_t;

	// channel payloads
	typedef struct packed {
		logic [7:0] in_ch0;
		logic [7:0] in_ch1;
		logic [7:0] in_ch2;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_ch0;
		logic [7:0]  out_ch1;
		logic [7:0]  out_ch2;
		logic [15:0] out_row;
		logic [10:0] out_col;
		logic        last;
	} out_item_t;

	// one classified item as it travels from front to back
	typedef struct packed {
		pix_t        up;
		pix_t        left;
		pix_t        ctr;
		pix_t        right;
		pix_t        down;
		logic [15:0] row;
		logic [10:0] col;
		logic        interior;
		logic        dual;
		logic        gray;
	} work_t;

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_CHANNEL_MODE = 2'd2
	} cfg_reg_t;

	localparam int CFG_DW = 16;
	localparam logic [11:0] WIDTH_RESET  = 12'd640;
	localparam logic [15:0] HEIGHT_RESET = 16'd480;
	localparam logic        MODE_RESET   = 1'b1;

	// front-to-back queue
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

endpackage

// ===== src/shp_stream_if.sv =====
// Valid/ready stream channel carrying one payload of type T per transfer.
// No dependencies; the payload type is supplied by the instantiating code.
interface shp_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== src/shp_line_mem.sv =====
// One line store bank: single write port, single read port, registered read.
// Read-first: a read and write to the same address return the old word.
module shp_line_mem import shp_pkg::*; #(
	parameter int DEPTH = 2048,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  pix_t          wdata,
	input  logic [AW-1:0] raddr,
	output pix_t          rdata
);

	pix_t mem [DEPTH];

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

// ===== src/shp_front.sv =====
// Front end: accepts pixels, keeps row/column counters and both line stores,
// gathers the 3x3 cross neighborhood and pushes classified items to the queue.
// Depends on shp_pkg, shp_stream_if and shp_line_mem.
module shp_front import shp_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic           clk,
	input  logic           arst_n,
	shp_stream_if.sink     pixel,
	input  logic [11:0]    image_width,
	input  logic [15:0]    image_height,
	input  logic           channel_mode,
	input  logic [QCW-1:0] queue_count,
	output logic           push,
	output work_t          push_item
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int WW = (CW > 12) ? CW : 12;

	logic [WW-1:0] wide_w;
	logic [CW-1:0] eff_w;
	logic [15:0]   eff_h;

	logic [AW-1:0] col_q;
	logic [15:0]   row_q;
	logic          bank_q;

	logic          accept;
	logic [AW-1:0] c;
	logic [15:0]   r;
	logic [CW-1:0] c_next;
	logic [16:0]   r_next;
	logic          last_col;
	logic          last_row;
	logic          row_wrap;
	pix_t          px;
	logic [AW-1:0] addr_c1;

	pix_t          col0_q [2];
	pix_t          rd0;
	pix_t          rd1;

	logic          valid_s1;
	logic          bank_s1;
	logic [AW-1:0] c_s1;
	logic [15:0]   row_s1;
	logic [10:0]   col_s1;
	logic          interior_s1;
	logic          dual_s1;
	logic          has_out_s1;
	logic          gray_s1;
	pix_t          px_s1;
	pix_t          col0_s1;

	pix_t          left_q;
	pix_t          ctr_q;
	pix_t          up;
	pix_t          right;
	pix_t          ctr;

	// effective frame size
	assign wide_w = WW'(image_width);
	always_comb begin
		if (wide_w < WW'(3)) begin
			eff_w = CW'(3);
		end else if (wide_w > WW'(MAX_WIDTH)) begin
			eff_w = CW'(MAX_WIDTH);
		end else begin
			eff_w = wide_w[CW-1:0];
		end
	end
	assign eff_h = (image_height < 16'd3) ? 16'd3 : image_height;

	// counters found beyond their bound restart at zero
	assign c = (CW'(col_q) >= eff_w) ? '0 : col_q;
	assign r = (row_q >= eff_h) ? 16'd0 : row_q;

	assign c_next   = CW'(c) + CW'(1);
	assign r_next   = {1'b0, r} + 17'd1;
	assign last_col = c_next >= eff_w;
	assign last_row = r_next == {1'b0, eff_h};
	assign row_wrap = r_next >= {1'b0, eff_h};

	assign px = {channel_mode ? pixel.data.in_ch2 : 8'h00,
		channel_mode ? pixel.data.in_ch1 : 8'h00,
		pixel.data.in_ch0};

	// room for this item plus the one still in stage 1
	assign pixel.ready = ((QCW+1)'(queue_count) + (QCW+1)'(valid_s1)) < (QCW+1)'(QDEPTH);
	assign accept = pixel.valid && pixel.ready;

	assign addr_c1 = c + AW'(1);

	// bank bank_q holds row r-2 (overwritten with row r), the other holds row r-1
	shp_line_mem #(.DEPTH(MAX_WIDTH), .AW(AW)) u_mem0 (
		.clk   (clk),
		.we    (accept && !bank_q),
		.waddr (c),
		.wdata (px),
		.raddr (bank_q ? addr_c1 : c),
		.rdata (rd0)
	);

	shp_line_mem #(.DEPTH(MAX_WIDTH), .AW(AW)) u_mem1 (
		.clk   (clk),
		.we    (accept && bank_q),
		.waddr (c),
		.wdata (px),
		.raddr (bank_q ? c : addr_c1),
		.rdata (rd1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= 16'd0;
			bank_q   <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (last_col) begin
					col_q  <= '0;
					bank_q <= ~bank_q;
					row_q  <= row_wrap ? 16'd0 : r_next[15:0];
				end else begin
					col_q <= c_next[AW-1:0];
				end
			end
		end
	end

	// column 0 of each bank shadowed so the left end of the window needs no second read
	always_ff @(posedge clk) begin
		if (accept && c == '0) begin
			col0_q[bank_q] <= px;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bank_s1     <= bank_q;
			c_s1        <= c;
			row_s1      <= r - 16'd1;
			col_s1      <= 11'(c);
			interior_s1 <= (r >= 16'd2) && (c != '0) && !last_col;
			dual_s1     <= last_row;
			has_out_s1  <= r != 16'd0;
			gray_s1     <= !channel_mode;
			px_s1       <= px;
			col0_s1     <= col0_q[~bank_q];
		end
	end

	// sliding window over the row above
	assign up    = bank_s1 ? rd1 : rd0;
	assign right = bank_s1 ? rd0 : rd1;
	assign ctr   = (c_s1 == '0) ? col0_s1 : ctr_q;

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			left_q <= ctr;
			ctr_q  <= right;
		end
	end

	assign push = valid_s1 && has_out_s1;
	always_comb begin
		push_item.up       = up;
		push_item.left     = left_q;
		push_item.ctr      = ctr;
		push_item.right    = right;
		push_item.down     = px_s1;
		push_item.row      = row_s1;
		push_item.col      = col_s1;
		push_item.interior = interior_s1;
		push_item.dual     = dual_s1;
		push_item.gray     = gray_s1;
	end

endmodule

// ===== src/shp_queue.sv =====
// Short FIFO of classified items between front and back.
// Depends on shp_pkg; the front never pushes when the queue is full.
module shp_queue import shp_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  work_t          push_item,
	input  logic           pop,
	output work_t          head,
	output logic           not_empty,
	output logic [QCW-1:0] count
);

	work_t          entries_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QCW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QAW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= push_item;
		end
	end

	assign head      = entries_q[rd_q];
	assign not_empty = count_q != '0;
	assign count     = count_q;

endmodule

// ===== src/shp_back.sv =====
// Back end: computes the sharpen kernel for the queue head and drives the
// result register; a last-row item also emits its zero border pixel.
// Depends on shp_pkg and shp_stream_if.
module shp_back import shp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  work_t        head,
	input  logic         not_empty,
	output logic         pop,
	shp_stream_if.source result
);

	logic      out_valid_q;
	logic      second_q;
	out_item_t out_q;
	logic      load;
	logic [7:0] k0;
	logic [7:0] k1;
	logic [7:0] k2;

	// 5*ctr - left - right - up - down, clamped to a byte
	function automatic logic [7:0] sharpen(input logic [7:0] ctr, input logic [7:0] lf,
		input logic [7:0] rt, input logic [7:0] up, input logic [7:0] dn);
		logic [10:0] gain;
		logic [9:0]  loss;
		logic [11:0] diff;
		logic [7:0]  res;
		gain = {1'b0, ctr, 2'b00} + 11'(ctr);
		loss = 10'(lf) + 10'(rt) + 10'(up) + 10'(dn);
		diff = 12'(gain) - 12'(loss);
		if (diff[11]) begin
			res = 8'd0;
		end else if (diff > 12'd255) begin
			res = 8'd255;
		end else begin
			res = diff[7:0];
		end
		return res;
	endfunction

	assign k0 = sharpen(head.ctr[7:0], head.left[7:0], head.right[7:0],
		head.up[7:0], head.down[7:0]);
	assign k1 = sharpen(head.ctr[15:8], head.left[15:8], head.right[15:8],
		head.up[15:8], head.down[15:8]);
	assign k2 = sharpen(head.ctr[23:16], head.left[23:16], head.right[23:16],
		head.up[23:16], head.down[23:16]);

	assign load = !out_valid_q || result.ready;
	// a dual item stays at the head until its border pixel is loaded into the result register
	assign pop  = load && not_empty && (second_q || !head.dual);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else if (load) begin
			out_valid_q <= not_empty;
			if (not_empty) begin
				second_q <= second_q ? 1'b0 : head.dual;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && not_empty) begin
			out_q.out_col <= head.col;
			if (second_q) begin
				out_q.out_ch0 <= 8'd0;
				out_q.out_ch1 <= 8'd0;
				out_q.out_ch2 <= 8'd0;
				out_q.out_row <= head.row + 16'd1;
				out_q.last    <= 1'b1;
			end else begin
				out_q.out_ch0 <= head.interior ? k0 : 8'd0;
				out_q.out_ch1 <= (head.interior && !head.gray) ? k1 : 8'd0;
				out_q.out_ch2 <= (head.interior && !head.gray) ? k2 : 8'd0;
				out_q.out_row <= head.row;
				out_q.last    <= !head.dual;
			end
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

endmodule

// ===== src/sharpen_3x3_stream_top.sv =====
// Channel   Dir  Handshake              Payload
// pixel     in   pixel.valid/ready      in_ch0, in_ch1, in_ch2
// result    out  result.valid/ready     out_ch0..2, out_row, out_col, last
// cfg       in   cfg_we (no wait)       cfg_index, cfg_data
//
// One pixel is taken per cycle while the queue has room; each line-store bank
// has one read and one write port, and column 0 is shadowed in a register so
// one read per bank suffices. Pixels of the last row give two results each, so
// there the output sets the pace. The first result of a pixel passes the stage-1
// registers, the queue and the result register before it is valid.
// Reset clears counters, bank select and handshake state; line stores are not
// cleared. Either side may stall; a four-entry queue decouples front and back.
module sharpen_3x3_stream_top import shp_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	shp_stream_if.sink        pixel,
	shp_stream_if.source      result
);

	logic [11:0]    image_width_q;
	logic [15:0]    image_height_q;
	logic           channel_mode_q;

	logic           push;
	work_t          push_item;
	logic           pop;
	work_t          head;
	logic           not_empty;
	logic [QCW-1:0] count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
			channel_mode_q <= MODE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[11:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[15:0];
				REG_CHANNEL_MODE: channel_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	shp_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel        (pixel),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.channel_mode (channel_mode_q),
		.queue_count  (count),
		.push         (push),
		.push_item    (push_item)
	);

	shp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.count     (count)
	);

	shp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.not_empty (not_empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
